>>> rtl/windowed_frame_rate_meter_defines.svh
// Assertion macros used by the windowed frame rate meter top level.
`ifndef WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`ifndef SYNTH
`define WFRM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("windowed_frame_rate_meter: assertion failed");
`define WFRM_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("windowed_frame_rate_meter: assertion failed");
`else
`define WFRM_ASSERT(label, clk, rst_n, prop)
`define WFRM_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> rtl/wfrm_pkg.sv
package wfrm_pkg;

  localparam int TICK_W  = 16;
  localparam int SUM_W   = 32;
  localparam int FPS_W   = 24;
  localparam int IDLE_W  = 14;
  localparam int HELD_W  = 11;

  localparam int RING_DEPTH = 1024;

  localparam int DIV_W   = 48;
  localparam int DEN_W   = SUM_W + 1;
  localparam int DIV_CW  = $clog2(DIV_W);

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd1000;

  // Scales are doubled so that rounding half up becomes (2n + d) / 2d.
  localparam logic [17:0] FPS_SCALE2  = 18'd200000;
  localparam logic [14:0] IDLE_SCALE2 = 15'd20000;
  localparam logic [FPS_W-1:0]  FPS_MAX  = 24'hFFFFFF;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 14'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL,
    ST_APPEND,
    ST_EVICT,
    ST_EVICT_WAIT,
    ST_FPS,
    ST_FPS_WAIT,
    ST_PCT,
    ST_PCT_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/wfrm_if.sv
interface wfrm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wfrm_pkg::TICK_W-1:0] frame_total_ticks;
  logic [wfrm_pkg::TICK_W-1:0] frame_idle_ticks;

  modport source (output valid, frame_total_ticks, frame_idle_ticks, input ready);
  modport sink   (input valid, frame_total_ticks, frame_idle_ticks, output ready);
endinterface

interface wfrm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ready_res;
  logic [wfrm_pkg::FPS_W-1:0]  fps_hundredths;
  logic [wfrm_pkg::IDLE_W-1:0] idle_hundredths;
  logic [wfrm_pkg::HELD_W-1:0] frames_held;

  modport source (output valid, ready_res, fps_hundredths, idle_hundredths, frames_held,
                  input ready);
  modport sink   (input valid, ready_res, fps_hundredths, idle_hundredths, frames_held,
                  output ready);
endinterface

>>> rtl/wfrm_div.sv
module wfrm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wfrm_pkg::DIV_W-1:0]  num,
  input  logic [wfrm_pkg::DEN_W-1:0]  den,
  output wfrm_pkg::div_status_t       status,
  output logic [wfrm_pkg::DIV_W-1:0]  quot
);
  import wfrm_pkg::*;

  logic [DIV_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, num_r[DIV_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quot        = num_r;

endmodule

>>> rtl/wfrm_ring.sv
module wfrm_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [wfrm_pkg::TICK_W-1:0] wr_total,
  input  logic [wfrm_pkg::TICK_W-1:0] wr_idle,
  input  logic [AW-1:0]               rd_addr,
  output logic [wfrm_pkg::TICK_W-1:0] rd_total,
  output logic [wfrm_pkg::TICK_W-1:0] rd_idle
);
  import wfrm_pkg::*;

  logic [2*TICK_W-1:0] mem [DEPTH];
  logic [2*TICK_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_total, wr_idle};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  assign rd_total = rd_r[2*TICK_W-1:TICK_W];
  assign rd_idle  = rd_r[TICK_W-1:0];

endmodule

>>> rtl/windowed_frame_rate_meter.sv
// Windowed frame rate meter. Each transfer on the input channel reports one frame (total and
// idle ticks, ticks in milliseconds); the frame is stored in a ring of RING_DEPTH entries and
// one result transfer follows with the ready flag, the frame rate in hundredths of frames per
// second, the idle share in hundredths of a percent and the number of frames held. When the
// ring is full the oldest frame is dropped first; then oldest frames are dropped while more
// than one frame is held and the retained ticks minus the oldest frame still exceed
// window_ticks (register 0, byte address 0, reset 1000). Each drop reads the ring through
// its registered read port, and the two rounded divisions by the tick sum run one quotient
// bit per cycle on a single shared 48-bit restoring divider. When the window is not yet
// filled the divisions are skipped. The input is accepted only when the sequencer is idle;
// a finished result waits in the output register without blocking the next input transfer.
// The ring holds no reset value and needs no clearing pass.
`include "windowed_frame_rate_meter_defines.svh"

module windowed_frame_rate_meter (
  input  logic                         clk,
  input  logic                         rst_n,
  wfrm_in_if.sink                      in_ch,
  wfrm_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wfrm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [wfrm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [wfrm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import wfrm_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HW = $clog2(RING_DEPTH + 1);
  localparam logic [HW-1:0] HELD_MAX   = HW'(RING_DEPTH);
  localparam logic [AW-1:0] OLDEST_TOP = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT  = (AW+1)'(RING_DEPTH);

  state_t state_r, state_nxt;

  logic [TICK_W-1:0] window_r;
  logic [AW-1:0]     oldest_r, oldest_nxt;
  logic [HW-1:0]     held_r, held_nxt;
  logic [SUM_W-1:0]  sum_total_r, sum_total_nxt;
  logic [SUM_W-1:0]  sum_idle_r, sum_idle_nxt;
  logic [TICK_W-1:0] t_r, t_nxt;
  logic [TICK_W-1:0] i_r, i_nxt;
  logic              ready_r, ready_nxt;
  logic [FPS_W-1:0]  fps_r, fps_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ready_res_r;
  logic [FPS_W-1:0]  out_fps_r;
  logic [IDLE_W-1:0] out_idle_r;
  logic [HELD_W-1:0] out_held_r;
  logic              out_load;

  logic [TICK_W-1:0] rd_total;
  logic [TICK_W-1:0] rd_idle;
  logic              wr_en;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     oldest_inc;
  logic [SUM_W-1:0]  rest_total;
  logic              evict_go;
  logic              do_drop;
  logic              in_xfer;
  logic              cfg_wr;

  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [DIV_W-1:0]  div_quot;
  div_status_t       div_st;
  logic [HW+17:0]    fps_prod;
  logic [SUM_W+14:0] idle_prod;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2:2] == REG_WINDOW);
  assign cfg_prdata = (cfg_paddr[2:2] == REG_WINDOW) ? CFG_DW'(window_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_r <= cfg_pwdata[TICK_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign slot_sum   = {1'b0, oldest_r} + (AW+1)'(held_r);
  assign slot       = (slot_sum >= DEPTH_EXT) ? AW'(slot_sum - DEPTH_EXT) : AW'(slot_sum);
  assign oldest_inc = (oldest_r == OLDEST_TOP) ? '0 : oldest_r + 1'b1;
  assign rest_total = sum_total_r - SUM_W'(rd_total);
  assign evict_go   = (held_r > HW'(1)) && (rest_total > SUM_W'(window_r));
  assign wr_en      = (state_r == ST_APPEND);

  assign fps_prod  = held_r * FPS_SCALE2;
  assign idle_prod = sum_idle_r * IDLE_SCALE2;
  assign div_den   = {sum_total_r, 1'b0};

  wfrm_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (slot),
    .wr_total (t_r),
    .wr_idle  (i_r),
    .rd_addr  (oldest_r),
    .rd_total (rd_total),
    .rd_idle  (rd_idle)
  );

  wfrm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_st),
    .quot   (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    sum_total_nxt = sum_total_r;
    sum_idle_nxt  = sum_idle_r;
    t_nxt         = t_r;
    i_nxt         = i_r;
    ready_nxt     = ready_r;
    fps_nxt       = fps_r;
    idle_nxt      = idle_r;
    do_drop       = 1'b0;
    div_start     = 1'b0;
    div_num       = DIV_W'(fps_prod) + DIV_W'(sum_total_r);
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          t_nxt     = in_ch.frame_total_ticks;
          i_nxt     = in_ch.frame_idle_ticks;
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        do_drop   = (held_r == HELD_MAX);
        state_nxt = ST_APPEND;
      end
      ST_APPEND: begin
        held_nxt      = held_r + 1'b1;
        sum_total_nxt = sum_total_r + SUM_W'(t_r);
        sum_idle_nxt  = sum_idle_r + SUM_W'(i_r);
        state_nxt     = ST_EVICT;
      end
      ST_EVICT: begin
        if (evict_go) begin
          do_drop   = 1'b1;
          state_nxt = ST_EVICT_WAIT;
        end else begin
          ready_nxt = (sum_total_r >= SUM_W'(window_r));
          fps_nxt   = '0;
          idle_nxt  = '0;
          if ((sum_total_r >= SUM_W'(window_r)) && (sum_total_r != '0)) begin
            state_nxt = ST_FPS;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_EVICT_WAIT: begin
        state_nxt = ST_EVICT;
      end
      ST_FPS: begin
        div_start = 1'b1;
        state_nxt = ST_FPS_WAIT;
      end
      ST_FPS_WAIT: begin
        if (div_st.done) begin
          fps_nxt   = (div_quot > DIV_W'(FPS_MAX)) ? FPS_MAX : div_quot[FPS_W-1:0];
          state_nxt = ST_PCT;
        end
      end
      ST_PCT: begin
        div_num   = DIV_W'(idle_prod) + DIV_W'(sum_total_r);
        div_start = 1'b1;
        state_nxt = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (div_st.done) begin
          idle_nxt  = (div_quot > DIV_W'(IDLE_MAX)) ? IDLE_MAX : div_quot[IDLE_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_drop) begin
      sum_total_nxt = sum_total_r - SUM_W'(rd_total);
      sum_idle_nxt  = sum_idle_r - SUM_W'(rd_idle);
      oldest_nxt    = oldest_inc;
      held_nxt      = held_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      held_r      <= '0;
      sum_total_r <= '0;
      sum_idle_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      sum_total_r <= sum_total_nxt;
      sum_idle_r  <= sum_idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    i_r    <= i_nxt;
    ready_r <= ready_nxt;
    fps_r  <= fps_nxt;
    idle_r <= idle_nxt;
    if (out_load) begin
      out_ready_res_r <= ready_r;
      out_fps_r       <= fps_r;
      out_idle_r      <= idle_r;
      out_held_r      <= HELD_W'(held_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ready_res       = out_ready_res_r;
  assign out_ch.fps_hundredths  = out_fps_r;
  assign out_ch.idle_hundredths = out_idle_r;
  assign out_ch.frames_held     = out_held_r;

  `WFRM_ASSERT(a_held_bound, clk, rst_n, held_r <= HELD_MAX)
  `WFRM_ASSERT(a_accept_div_idle, clk, rst_n, in_xfer |-> !div_st.busy)
  `WFRM_ASSERT(a_evict_shrinks, clk, rst_n, (state_r == ST_EVICT && evict_go) |=> (held_r == $past(held_r) - 1'b1))
  `WFRM_ASSERT(a_not_ready_zero, clk, rst_n, (out_valid_r && !out_ready_res_r) |-> (out_fps_r == '0 && out_idle_r == '0))

endmodule
